// ===== hdl/hdpp_pkg.sv =====
// Package: phase codes, character constants and the shared result struct for the path parser.
package hdpp_pkg;

  localparam int PhaseW = 2;
  localparam logic [PhaseW-1:0] PH_EXPECT_M     = 2'd0;
  localparam logic [PhaseW-1:0] PH_EXPECT_SLASH = 2'd1;
  localparam logic [PhaseW-1:0] PH_SEGMENT      = 2'd2;

  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_UPH   = 8'h48;
  localparam logic [7:0] CH_LOWH  = 8'h68;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [31:0] HARDEN_BIT = 32'h8000_0000;
  localparam logic [31:0] ACC_LIMIT  = 32'd429496729;
  localparam logic [3:0]  DIGIT_LIMIT = 4'd5;
  localparam logic [7:0]  IDX_MAX    = 8'hFF;

  typedef struct packed {
    logic        seg_ready;
    logic [31:0] seg_value;
    logic [7:0]  seg_index;
    logic        done;
    logic        ok;
  } result_t;

endpackage

// ===== hdl/hdpp_parser.sv =====
// Parser state registers and per-character next-state and result logic.
module hdpp_parser
  import hdpp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] path_char,
  input  logic       last_char,
  output logic       res_valid,
  output result_t    res
);

  logic [PhaseW-1:0] phase, phase_next;
  logic [31:0]       acc, acc_next;
  logic              have_digit, have_digit_next;
  logic              hardened, hardened_next;
  logic              path_error, path_error_next;
  logic [7:0]        counter, counter_next;

  logic              is_digit;
  logic              is_suffix;
  logic [3:0]        digit;
  logic [31:0]       acc_x10;
  logic              overflow;
  logic              ok;

  assign is_digit  = (path_char >= CH_ZERO) && (path_char <= CH_NINE);
  assign is_suffix = (path_char == CH_APOS) || (path_char == CH_UPH) || (path_char == CH_LOWH);
  assign digit     = 4'(path_char - CH_ZERO);
  assign acc_x10   = {acc[28:0], 3'b000} + {acc[30:0], 1'b0};
  assign overflow  = (acc > ACC_LIMIT) || ((acc == ACC_LIMIT) && (digit > DIGIT_LIMIT));

  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    have_digit_next = have_digit;
    hardened_next   = hardened;
    path_error_next = path_error;
    counter_next    = counter;
    res             = '0;
    res_valid       = 1'b0;
    ok              = 1'b0;

    if (!path_error) begin
      case (phase)
        PH_EXPECT_M: begin
          if (path_char == CH_M) phase_next = PH_EXPECT_SLASH;
          else path_error_next = 1'b1;
        end
        PH_EXPECT_SLASH: begin
          if (path_char == CH_SLASH) begin
            phase_next      = PH_SEGMENT;
            acc_next        = '0;
            have_digit_next = 1'b0;
            hardened_next   = 1'b0;
          end else begin
            path_error_next = 1'b1;
          end
        end
        PH_SEGMENT: begin
          if (is_digit) begin
            if (hardened || overflow) begin
              path_error_next = 1'b1;
            end else begin
              acc_next        = acc_x10 + {28'd0, digit};
              have_digit_next = 1'b1;
            end
          end else if (is_suffix) begin
            if (!have_digit || hardened) path_error_next = 1'b1;
            else hardened_next = 1'b1;
          end else if (path_char == CH_SLASH) begin
            if (have_digit) begin
              res.seg_ready   = 1'b1;
              res.seg_value   = acc + (hardened ? HARDEN_BIT : 32'd0);
              res.seg_index   = counter;
              res_valid       = 1'b1;
              if (counter != IDX_MAX) counter_next = counter + 8'd1;
              acc_next        = '0;
              have_digit_next = 1'b0;
              hardened_next   = 1'b0;
            end else begin
              path_error_next = 1'b1;
            end
          end else begin
            path_error_next = 1'b1;
          end
        end
        default: path_error_next = 1'b1;
      endcase
    end

    if (last_char) begin
      ok = !path_error_next && (phase_next == PH_SEGMENT) && have_digit_next;
      if (ok) begin
        res.seg_ready = 1'b1;
        res.seg_value = acc_next + (hardened_next ? HARDEN_BIT : 32'd0);
        res.seg_index = counter_next;
      end
      res.done        = 1'b1;
      res.ok          = ok;
      res_valid       = 1'b1;
      phase_next      = PH_EXPECT_M;
      acc_next        = '0;
      have_digit_next = 1'b0;
      hardened_next   = 1'b0;
      path_error_next = 1'b0;
      counter_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_EXPECT_M;
      acc        <= '0;
      have_digit <= 1'b0;
      hardened   <= 1'b0;
      path_error <= 1'b0;
      counter    <= '0;
    end else if (fire) begin
      phase      <= phase_next;
      acc        <= acc_next;
      have_digit <= have_digit_next;
      hardened   <= hardened_next;
      path_error <= path_error_next;
      counter    <= counter_next;
    end
  end

endmodule

// ===== hdl/hdpp_out_reg.sv =====
// Result register holding one result until the consumer takes it.
module hdpp_out_reg
  import hdpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     res,
  input  logic        result_ready,
  output logic        result_valid,
  output logic        segment_ready,
  output logic [31:0] segment_value,
  output logic [7:0]  segment_index,
  output logic        path_done,
  output logic        path_ok
);

  result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign segment_ready = held.seg_ready;
  assign segment_value = held.seg_value;
  assign segment_index = held.seg_index;
  assign path_done     = held.done;
  assign path_ok       = held.ok;

endmodule

// ===== hdl/hd_derivation_path_parser.sv =====
// Top level of the derivation path parser: one character per request, zero or one result.
//
//   channel  handshake                  payload
//   char     char_valid / char_ready    path_char[7:0], last_char
//   result   result_valid / result_ready segment_ready, segment_value[31:0],
//                                       segment_index[7:0], path_done, path_ok
//
// One character is taken per cycle while char_ready is high; its result appears in the
// result register the next cycle. The single result register sets the rate: char_ready
// is high whenever that register is empty or being drained in the same cycle.
// Reset clears the parse state and the result valid flag.
// A stalled result blocks new characters only while it is not taken.
module hd_derivation_path_parser
  import hdpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_ready,
  input  logic [7:0]  path_char,
  input  logic        last_char,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        segment_ready,
  output logic [31:0] segment_value,
  output logic [7:0]  segment_index,
  output logic        path_done,
  output logic        path_ok
);

  logic    fire;
  logic    res_valid;
  result_t res;

  assign char_ready = !result_valid || result_ready;
  assign fire       = char_valid && char_ready;

  hdpp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .path_char (path_char),
    .last_char (last_char),
    .res_valid (res_valid),
    .res       (res)
  );

  hdpp_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (fire && res_valid),
    .res           (res),
    .result_ready  (result_ready),
    .result_valid  (result_valid),
    .segment_ready (segment_ready),
    .segment_value (segment_value),
    .segment_index (segment_index),
    .path_done     (path_done),
    .path_ok       (path_ok)
  );

endmodule

// ===== dv/hdpp_checker.sv =====
// Checker for the path parser: tracks parse state per accepted character and compares results.
`timescale 1ns / 1ps

module hdpp_checker
  import hdpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  input  logic        char_ready,
  input  logic [7:0]  path_char,
  input  logic        last_char,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic        segment_ready,
  input  logic [31:0] segment_value,
  input  logic [7:0]  segment_index,
  input  logic        path_done,
  input  logic        path_ok,
  output int          fail_count,
  output int          pending
);

  logic [PhaseW-1:0] phase;
  logic [31:0]       acc;
  logic              have_digit;
  logic              hardened;
  logic              bad;
  logic [7:0]        seg_count;
  result_t           expected_q[$];

  task automatic clear_path();
    phase = PH_EXPECT_M;
    acc = '0;
    have_digit = 1'b0;
    hardened = 1'b0;
    bad = 1'b0;
    seg_count = '0;
  endtask

  task automatic load_segment(inout result_t r);
    r.seg_ready = 1'b1;
    r.seg_value = acc + (hardened ? HARDEN_BIT : 32'd0);
    r.seg_index = seg_count;
    if (seg_count != IDX_MAX) seg_count = seg_count + 8'd1;
  endtask

  task automatic predict_char(input logic [7:0] c, input logic last);
    result_t    r;
    logic       hit;
    logic       ok;
    logic [3:0] d;
    r = '0;
    hit = 1'b0;
    if (!bad) begin
      case (phase)
        PH_EXPECT_M: begin
          if (c == CH_M) phase = PH_EXPECT_SLASH;
          else bad = 1'b1;
        end
        PH_EXPECT_SLASH: begin
          if (c == CH_SLASH) begin
            phase = PH_SEGMENT;
            acc = '0;
            have_digit = 1'b0;
            hardened = 1'b0;
          end else begin
            bad = 1'b1;
          end
        end
        default: begin
          if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c[3:0];
            if (hardened || acc > ACC_LIMIT || (acc == ACC_LIMIT && d > DIGIT_LIMIT)) begin
              bad = 1'b1;
            end else begin
              acc = acc * 32'd10 + {28'd0, d};
              have_digit = 1'b1;
            end
          end else if (c == CH_APOS || c == CH_UPH || c == CH_LOWH) begin
            if (!have_digit || hardened) bad = 1'b1;
            else hardened = 1'b1;
          end else if (c == CH_SLASH) begin
            if (have_digit) begin
              load_segment(r);
              hit = 1'b1;
              acc = '0;
              have_digit = 1'b0;
              hardened = 1'b0;
            end else begin
              bad = 1'b1;
            end
          end else begin
            bad = 1'b1;
          end
        end
      endcase
    end
    if (last) begin
      ok = !bad && phase == PH_SEGMENT && have_digit;
      if (ok) load_segment(r);
      r.done = 1'b1;
      r.ok = ok;
      hit = 1'b1;
      clear_path();
    end
    if (hit) expected_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < 100)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    fail_count = fail_count + 1;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_path();
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no request pending", segment_value, 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (segment_ready !== want.seg_ready)
            report_mismatch("segment_ready", {31'd0, segment_ready}, {31'd0, want.seg_ready});
          if (segment_value !== want.seg_value)
            report_mismatch("segment_value", segment_value, want.seg_value);
          if (segment_index !== want.seg_index)
            report_mismatch("segment_index", {24'd0, segment_index}, {24'd0, want.seg_index});
          if (path_done !== want.done)
            report_mismatch("path_done", {31'd0, path_done}, {31'd0, want.done});
          if (path_ok !== want.ok)
            report_mismatch("path_ok", {31'd0, path_ok}, {31'd0, want.ok});
        end
      end
      if (char_valid && char_ready) predict_char(path_char, last_char);
    end
    pending = expected_q.size();
  end

endmodule

// ===== dv/hd_derivation_path_parser_tb.sv =====
// Testbench top for the path parser: clock, reset, character requests, result stalls, verdict.
`timescale 1ns / 1ps

module hd_derivation_path_parser_tb;
  import hdpp_pkg::*;

  localparam int RandomChars = 1150;
  localparam int QuietAfter  = 1000;
  localparam int StallLimit  = 200;

  logic        clk;
  logic        rst = 1'b1;
  logic        char_valid = 1'b0;
  logic        char_ready;
  logic [7:0]  path_char = '0;
  logic        last_char = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b1;
  logic        segment_ready;
  logic [31:0] segment_value;
  logic [7:0]  segment_index;
  logic        path_done;
  logic        path_ok;

  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  int          sent_chars = 0;
  logic        quiet = 1'b0;
  logic [7:0]  path_buf[$];

  hd_derivation_path_parser dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .path_char    (path_char),
    .last_char    (last_char),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .segment_ready(segment_ready),
    .segment_value(segment_value),
    .segment_index(segment_index),
    .path_done    (path_done),
    .path_ok      (path_ok)
  );

  hdpp_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .path_char    (path_char),
    .last_char    (last_char),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .segment_ready(segment_ready),
    .segment_value(segment_value),
    .segment_index(segment_index),
    .path_done    (path_done),
    .path_ok      (path_ok),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((char_valid && char_ready) || (result_valid && result_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= StallLimit);
    $display("hd_derivation_path_parser regression: fail");
    $finish;
  end

  initial begin : result_stalls
    int stall;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        result_ready <= 1'b0;
        stall = $urandom_range(1, 3);
        repeat (stall) @(negedge clk);
        result_ready <= 1'b1;
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      char_valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
    end
    char_valid <= 1'b1;
    path_char <= c;
    last_char <= last;
    do @(posedge clk); while (!char_ready);
    sent_chars = sent_chars + 1;
    @(negedge clk);
  endtask

  task automatic send_path();
    for (int i = 0; i < path_buf.size(); i++) send_char(path_buf[i], i == path_buf.size() - 1);
    path_buf.delete();
  endtask

  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) path_buf.push_back(s[i]);
  endtask

  task automatic add_dec(input longint unsigned v, input int zeros);
    logic [7:0]       digits[$];
    longint unsigned  rest;
    rest = v;
    repeat (zeros) path_buf.push_back(CH_ZERO);
    do begin
      digits.push_front(CH_ZERO + 8'(rest % 10));
      rest = rest / 10;
    end while (rest != 0);
    foreach (digits[i]) path_buf.push_back(digits[i]);
  endtask

  task automatic add_segment();
    longint unsigned v;
    int              pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: v = $urandom_range(0, 99);
      4, 5:       v = $urandom;
      6:          v = 64'd4294967295;
      7:          v = 64'd4294967290 + $urandom_range(0, 5);
      8:          v = 64'd4294967290 + $urandom_range(0, 9);
      default:    v = 0;
    endcase
    add_dec(v, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0);
    case ($urandom_range(0, 5))
      0:       path_buf.push_back(CH_APOS);
      1:       path_buf.push_back(CH_UPH);
      2:       path_buf.push_back(CH_LOWH);
      default: ;
    endcase
  endtask

  task automatic build_random_path();
    int              kind;
    int              nseg;
    int              pos;
    longint unsigned big;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) path_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      path_buf.push_back(CH_M);
      path_buf.push_back(CH_SLASH);
      nseg = $urandom_range(1, 4);
      for (int i = 0; i < nseg; i++) begin
        add_segment();
        if (i < nseg - 1) path_buf.push_back(CH_SLASH);
      end
      if ($urandom_range(0, 9) == 0) path_buf.push_back(CH_SLASH);
      if (kind >= 8) begin
        pos = $urandom_range(0, path_buf.size() - 1);
        case ($urandom_range(0, 3))
          0: path_buf[pos] = 8'($urandom_range(0, 255));
          1: path_buf.insert(pos, 8'($urandom_range(0, 255)));
          2: while (path_buf.size() > pos + 1) void'(path_buf.pop_back());
          default: begin
            big = (longint'($urandom_range(1, 20)) << 32) | longint'($urandom);
            path_buf.push_back(CH_SLASH);
            add_dec(big, 0);
          end
        endcase
      end
    end
  endtask

  initial begin : stimulus
    int first_random;
    int paths;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // bad start on the extreme bytes, missing and empty segments, suffix misuse
    path_buf.push_back(8'h00);
    send_path();
    load_text("m");
    send_path();
    load_text("m");
    path_buf.push_back(8'hFF);
    send_path();
    load_text("m/");
    send_path();
    load_text("m/'");
    send_path();
    load_text("m/1Hh");
    send_path();
    load_text("m/9h2");
    send_path();
    load_text("m//");
    send_path();
    load_text("m/ ");
    send_path();
    load_text("m/0'/");
    send_path();

    first_random = sent_chars;
    paths = 0;
    while (sent_chars - first_random < RandomChars) begin
      if (paths == 3) begin
        // enough segments to saturate the index
        load_text("m/");
        for (int i = 0; i < 258; i++) begin
          path_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          if (i < 257) path_buf.push_back(CH_SLASH);
        end
      end else begin
        build_random_path();
      end
      send_path();
      paths = paths + 1;
      quiet = (sent_chars - first_random) > QuietAfter;
      if (paths % 10 == 0) begin
        char_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
      end
    end

    char_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(negedge clk);
    if (fail_count == 0) $display("hd_derivation_path_parser regression: pass");
    else $display("hd_derivation_path_parser regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/hdpp_pkg.sv
hdl/hdpp_parser.sv
hdl/hdpp_out_reg.sv
hdl/hd_derivation_path_parser.sv
dv/hdpp_checker.sv
dv/hd_derivation_path_parser_tb.sv
